### hw/rtl/mwg_pkg.sv
// Shared types, codes and the quarter-wave sine table for the waveform generator.
package mwg_pkg;

	// Item kinds
	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_TIMED = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	// Waveform selection; codes 6 and 7 give a zero waveform
	typedef enum logic [2:0] {
		WAVE_SINE   = 3'd0,
		WAVE_TRI    = 3'd1,
		WAVE_SAW    = 3'd2,
		WAVE_ISAW   = 3'd3,
		WAVE_SQUARE = 3'd4,
		WAVE_NOISE  = 3'd5
	} wave_t;

	// Register map
	localparam int unsigned CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_WAVE_TYPE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BIAS      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_AMP       = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MS_STEP   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SEED      = 3'd5;

	localparam logic [31:0] TICK_STEP_RST = 32'd429496730;
	localparam logic [31:0] NOISE_DEFAULT = 32'd2463534242;

	// Live configuration
	typedef struct packed {
		wave_t              wave_type;
		logic signed [31:0] bias;
		logic [31:0]        amp;
		logic [31:0]        tick_step;
		logic [31:0]        ms_step;
	} cfg_t;

	// Seed write towards the noise state
	typedef struct packed {
		logic        load;
		logic [31:0] value;
	} seed_wr_t;

	// One queued item: kind, phase to sample at, noise word for this item
	typedef struct packed {
		kind_t       kind;
		logic [31:0] phase;
		logic [31:0] noise;
	} qent_t;

	// Angle folding points, degrees with 32 fraction bits
	localparam logic [40:0] DEG180 = 41'h0B4_0000_0000;
	localparam logic [40:0] DEG90  = 41'h05A_0000_0000;

	// Quarter-wave sine, round(sin * 65536) at 1-degree steps
	localparam int unsigned SINE_TABLE_ENTRIES = 91;
	localparam int unsigned SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam logic [16:0] SINE_TBL [SINE_TABLE_ENTRIES] = '{
		17'd0,     17'd1144,  17'd2287,  17'd3430,  17'd4572,  17'd5712,  17'd6850,
		17'd7987,  17'd9121,  17'd10252, 17'd11380, 17'd12505, 17'd13626, 17'd14742,
		17'd15855, 17'd16962, 17'd18064, 17'd19161, 17'd20252, 17'd21336, 17'd22415,
		17'd23486, 17'd24550, 17'd25607, 17'd26656, 17'd27697, 17'd28729, 17'd29753,
		17'd30767, 17'd31773, 17'd32768, 17'd33754, 17'd34729, 17'd35693, 17'd36647,
		17'd37590, 17'd38521, 17'd39441, 17'd40348, 17'd41243, 17'd42126, 17'd42995,
		17'd43852, 17'd44695, 17'd45525, 17'd46341, 17'd47143, 17'd47930, 17'd48703,
		17'd49461, 17'd50203, 17'd50931, 17'd51643, 17'd52339, 17'd53020, 17'd53684,
		17'd54332, 17'd54963, 17'd55578, 17'd56175, 17'd56756, 17'd57319, 17'd57865,
		17'd58393, 17'd58903, 17'd59396, 17'd59870, 17'd60326, 17'd60764, 17'd61183,
		17'd61584, 17'd61966, 17'd62328, 17'd62672, 17'd62997, 17'd63303, 17'd63589,
		17'd63856, 17'd64104, 17'd64332, 17'd64540, 17'd64729, 17'd64898, 17'd65047,
		17'd65177, 17'd65287, 17'd65376, 17'd65446, 17'd65496, 17'd65526, 17'd65536
	};

endpackage

### hw/rtl/multi_waveform_generator.sv
// Top level of the multi-waveform generator: register file, front end, queue and back end.
//
//  channel  | signals                                | direction | payload
//  ---------+----------------------------------------+-----------+---------------------------
//  input    | in_valid, in_stall                     | in        | kind, elapsed_ms
//  output   | out_valid, out_stall                   | out       | sample
//  config   | cfg_valid, cfg_ready                   | in        | cfg_index, cfg_data
//
// The front end takes one item per cycle while the queue has room; the phase add (with a
// 32x32 multiply for a timed step) is the only recurrence.
// The back end delivers one sample per cycle unless out_stall holds it; a queued item moves
// through stage registers s1 to s6 into the output register. Output stall freezes
// the back-end pipeline only; the front keeps accepting until QUEUE_DEPTH items wait. Reset
// clears phase, restores the default noise state and register values; no clearing pass is needed.
module multi_waveform_generator #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic [1:0]                        kind,
	input  logic [31:0]                       elapsed_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic signed [31:0]                sample,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [mwg_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [31:0]                       cfg_data
);

	mwg_pkg::cfg_t     cfg_q;
	mwg_pkg::seed_wr_t seed_wr;
	logic              cfg_wr;
	logic              q_full, q_empty, push, pop;
	mwg_pkg::qent_t    push_ent, head_ent;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;

	// seed write loads the noise state in the front end
	assign seed_wr = '{load: cfg_wr && (cfg_index == mwg_pkg::REG_SEED), value: cfg_data};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.wave_type <= mwg_pkg::WAVE_SINE;
			cfg_q.bias      <= 32'sd0;
			cfg_q.amp       <= 32'd0;
			cfg_q.tick_step <= mwg_pkg::TICK_STEP_RST;
			cfg_q.ms_step   <= 32'd0;
		end else if (cfg_wr) begin
			case (cfg_index)
				mwg_pkg::REG_WAVE_TYPE: cfg_q.wave_type <= mwg_pkg::wave_t'(cfg_data[2:0]);
				mwg_pkg::REG_BIAS:      cfg_q.bias      <= signed'(cfg_data);
				mwg_pkg::REG_AMP:       cfg_q.amp       <= cfg_data;
				mwg_pkg::REG_TICK_STEP: cfg_q.tick_step <= cfg_data;
				mwg_pkg::REG_MS_STEP:   cfg_q.ms_step   <= cfg_data;
				default:                cfg_q           <= cfg_q;
			endcase
		end
	end

	mwg_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.elapsed_ms (elapsed_ms),
		.cfg        (cfg_q),
		.seed_wr    (seed_wr),
		.q_full     (q_full),
		.push       (push),
		.push_ent   (push_ent)
	);

	mwg_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ent (push_ent),
		.pop      (pop),
		.head_ent (head_ent),
		.full     (q_full),
		.empty    (q_empty)
	);

	mwg_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.q_empty   (q_empty),
		.head_ent  (head_ent),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sample    (sample)
	);

endmodule

### hw/rtl/mwg_front.sv
// Front end: accepts items, owns the phase and noise state, queues work for the back end.
module mwg_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [1:0]           kind,
	input  logic [31:0]          elapsed_ms,
	input  mwg_pkg::cfg_t        cfg,
	input  mwg_pkg::seed_wr_t    seed_wr,
	input  logic                 q_full,
	output logic                 push,
	output mwg_pkg::qent_t       push_ent
);

	logic              accept;
	mwg_pkg::kind_t    kind_in;
	logic [31:0]       phase_q;
	logic [31:0]       noise_q;
	logic [31:0]       nz1, nz2, nz3;
	logic              noise_adv;
	logic [63:0]       ms_prod;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;
	assign kind_in  = mwg_pkg::kind_t'(kind);

	// xorshift32: 13, 17, 5
	assign nz1 = noise_q ^ {noise_q[18:0], 13'd0};
	assign nz2 = nz1 ^ {17'd0, nz1[31:17]};
	assign nz3 = nz2 ^ {nz2[26:0], 5'd0};

	assign noise_adv = (cfg.wave_type == mwg_pkg::WAVE_NOISE) &&
		((kind_in == mwg_pkg::KIND_TICK) || (kind_in == mwg_pkg::KIND_TIMED));

	// timed phase advance, Q16.16 ms times per-ms step
	assign ms_prod = {32'd0, elapsed_ms} * {32'd0, cfg.ms_step};

	assign push     = accept;
	assign push_ent = '{kind: kind_in, phase: phase_q, noise: nz3};

	// phase accumulator and noise state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 32'd0;
			noise_q <= mwg_pkg::NOISE_DEFAULT;
		end else begin
			if (seed_wr.load) begin
				noise_q <= (seed_wr.value == 32'd0) ? mwg_pkg::NOISE_DEFAULT : seed_wr.value;
			end else if (accept && noise_adv) begin
				noise_q <= nz3;
			end
			if (accept) begin
				case (kind_in)
					mwg_pkg::KIND_TICK:  phase_q <= phase_q + cfg.tick_step;
					mwg_pkg::KIND_TIMED: phase_q <= phase_q + ms_prod[47:16];
					mwg_pkg::KIND_CLEAR: phase_q <= 32'd0;
					default:             phase_q <= phase_q;
				endcase
			end
		end
	end

endmodule

### hw/rtl/mwg_queue.sv
// Short FIFO of queued items between the front and back ends.
module mwg_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            push,
	input  mwg_pkg::qent_t  push_ent,
	input  logic            pop,
	output mwg_pkg::qent_t  head_ent,
	output logic            full,
	output logic            empty
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

	mwg_pkg::qent_t   ent_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full     = (cnt_q == CNT_W'(DEPTH));
	assign empty    = (cnt_q == '0);
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign head_ent = ent_q[rd_ptr_q];

	// entry storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[wr_ptr_q] <= push_ent;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

### hw/rtl/mwg_back.sv
// Back end: sample pipeline from queued phase to the saturated, scaled output beat.
module mwg_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mwg_pkg::cfg_t         cfg,
	input  logic                  q_empty,
	input  mwg_pkg::qent_t        head_ent,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic signed [31:0]    sample
);

	logic adv;

	// stage valids
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, out_valid_q;

	// stage payloads
	mwg_pkg::kind_t     kind_s1, kind_s2, kind_s3, kind_s4, kind_s5, kind_s6;
	logic [40:0]        d_s1;
	logic signed [19:0] aux_s1, aux_s2, aux_s3;
	logic [39:0]        d_s2;
	logic               neg_s2, neg_s3;
	logic [16:0]        ti_s3;
	logic [10:0]        diff_s3;
	logic [31:0]        frac_s3;
	logic signed [19:0] raw_s4;
	logic               bias_on_s4;
	logic signed [31:0] w_s5, w_s6;
	logic               neg_s6;
	logic [63:0]        prod_s6;
	logic signed [31:0] sample_q;

	// stage 1 logic
	logic [17:0]        tri_q;
	logic signed [19:0] tri_v;
	logic [49:0]        nz_num;
	logic [32:0]        nz_ab;
	logic [19:0]        nz_q;
	logic signed [19:0] aux_v;

	// stage 3 logic
	logic [38:0]                      d_fold;
	logic [mwg_pkg::SINE_IDX_W-1:0]   idx, idx_n;
	logic [16:0]                      t_lo, t_hi;

	// stage 4 logic
	logic [43:0]        ip_sum;
	logic [17:0]        sine_mag;
	logic signed [19:0] sine_v;

	// stage 5 logic
	logic signed [33:0] biased;

	// stage 6 logic
	logic [32:0]        neg_w;
	logic [31:0]        mag;

	// stage 7 logic
	logic [64:0]        rnd_sum;
	logic [48:0]        rmag;
	logic [48:0]        neg_r;
	logic signed [31:0] scaled;
	logic signed [31:0] sample_d;

	// whole pipeline moves when the output register can take a beat
	assign adv       = !out_valid_q || !out_stall;
	assign pop       = adv && !q_empty;
	assign out_valid = out_valid_q;
	assign sample    = sample_q;

	// stage 1: triangle, saw, square and noise from the queued words
	always_comb begin
		tri_q = head_ent.phase[31:14];
		if (head_ent.phase < 32'h4000_0000) begin
			tri_v = signed'({2'b00, tri_q});
		end else if (head_ent.phase < 32'hC000_0000) begin
			tri_v = 20'sd131072 - signed'({2'b00, tri_q});
		end else begin
			tri_v = signed'({2'b00, tri_q}) - 20'sd262144;
		end
		// round(x * 2^17 / (2^32 - 1)): quotient is hi word plus one carry step
		nz_num = {1'b0, head_ent.noise, 17'd0} + 50'h0_7FFF_FFFF;
		nz_ab  = {15'd0, nz_num[49:32]} + {1'b0, nz_num[31:0]};
		nz_q   = {2'd0, nz_num[49:32]} + {19'd0, (nz_ab >= 33'h0_FFFF_FFFF)};
		case (cfg.wave_type)
			mwg_pkg::WAVE_TRI:    aux_v = tri_v;
			mwg_pkg::WAVE_SAW:    aux_v = signed'({4'd0, head_ent.phase[31:16]});
			mwg_pkg::WAVE_ISAW:   aux_v = -signed'({4'd0, head_ent.phase[31:16]});
			mwg_pkg::WAVE_SQUARE: aux_v = head_ent.phase[31] ? -20'sd65536 : 20'sd65536;
			mwg_pkg::WAVE_NOISE:  aux_v = signed'(nz_q) - 20'sd65536;
			default:              aux_v = 20'sd0;
		endcase
	end

	// stage 3: fold to the first quadrant and look up the neighbours
	always_comb begin
		if ({1'b0, d_s2} > mwg_pkg::DEG90) begin
			d_fold = 39'(mwg_pkg::DEG180 - {1'b0, d_s2});
		end else begin
			d_fold = d_s2[38:0];
		end
		idx   = d_fold[38:32];
		idx_n = (idx == mwg_pkg::SINE_IDX_W'(mwg_pkg::SINE_TABLE_ENTRIES - 1)) ?
			idx : idx + 1'b1;
		t_lo  = mwg_pkg::SINE_TBL[idx];
		t_hi  = mwg_pkg::SINE_TBL[idx_n];
	end

	// stage 4: linear interpolation, round half up
	always_comb begin
		ip_sum   = ({33'd0, diff_s3} * {12'd0, frac_s3}) + 44'h0_8000_0000;
		sine_mag = {1'b0, ti_s3} + {6'd0, ip_sum[43:32]};
		sine_v   = neg_s3 ? -signed'({2'b00, sine_mag}) : signed'({2'b00, sine_mag});
	end

	// stage 5: bias and saturate
	always_comb begin
		biased = bias_on_s4 ?
			(34'(raw_s4) + 34'(cfg.bias)) : 34'(raw_s4);
	end

	// stage 6: magnitude for the gain
	assign neg_w = 33'd0 - {w_s5[31], w_s5};
	assign mag   = w_s5[31] ? neg_w[31:0] : w_s5;

	// stage 7: round half away from zero, restore sign, saturate, pick by kind
	always_comb begin
		rnd_sum = {1'b0, prod_s6} + 65'd32768;
		rmag    = rnd_sum[64:16];
		neg_r   = 49'd0 - rmag;
		if (neg_s6) begin
			scaled = (rmag > 49'h0_8000_0000) ? 32'sh8000_0000 : signed'(neg_r[31:0]);
		end else begin
			scaled = (rmag > 49'h0_7FFF_FFFF) ? 32'sh7FFF_FFFF : signed'(rmag[31:0]);
		end
		case (kind_s6)
			mwg_pkg::KIND_TICK:  sample_d = w_s6;
			mwg_pkg::KIND_TIMED: sample_d = scaled;
			default:             sample_d = 32'sd0;
		endcase
	end

	// stage valids
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			v_s5        <= 1'b0;
			v_s6        <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			v_s1        <= !q_empty;
			v_s2        <= v_s1;
			v_s3        <= v_s2;
			v_s4        <= v_s3;
			v_s5        <= v_s4;
			v_s6        <= v_s5;
			out_valid_q <= v_s6;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (adv) begin
			// stage 1: degrees = phase * 360 with 32 fraction bits
			kind_s1 <= head_ent.kind;
			d_s1    <= {9'd0, head_ent.phase} * 41'd360;
			aux_s1  <= aux_v;
			// stage 2: second half-turn folds with a sign flip
			kind_s2 <= kind_s1;
			aux_s2  <= aux_s1;
			if (d_s1 > mwg_pkg::DEG180) begin
				d_s2   <= 40'(d_s1 - mwg_pkg::DEG180);
				neg_s2 <= 1'b1;
			end else begin
				d_s2   <= d_s1[39:0];
				neg_s2 <= 1'b0;
			end
			// stage 3
			kind_s3 <= kind_s2;
			aux_s3  <= aux_s2;
			neg_s3  <= neg_s2;
			ti_s3   <= t_lo;
			diff_s3 <= 11'(t_hi - t_lo);
			frac_s3 <= d_fold[31:0];
			// stage 4
			kind_s4    <= kind_s3;
			raw_s4     <= (cfg.wave_type == mwg_pkg::WAVE_SINE) ? sine_v : aux_s3;
			bias_on_s4 <= (cfg.wave_type == mwg_pkg::WAVE_SINE) ||
				(cfg.wave_type == mwg_pkg::WAVE_TRI) ||
				(cfg.wave_type == mwg_pkg::WAVE_SQUARE) ||
				(cfg.wave_type == mwg_pkg::WAVE_NOISE);
			// stage 5
			kind_s5 <= kind_s4;
			if (biased > 34'sh0_7FFF_FFFF) begin
				w_s5 <= 32'sh7FFF_FFFF;
			end else if (biased < -34'sh0_8000_0000) begin
				w_s5 <= 32'sh8000_0000;
			end else begin
				w_s5 <= biased[31:0];
			end
			// stage 6
			kind_s6 <= kind_s5;
			w_s6    <= w_s5;
			neg_s6  <= w_s5[31];
			prod_s6 <= {32'd0, mag} * {32'd0, cfg.amp};
			// output register
			sample_q <= sample_d;
		end
	end

endmodule

### test/mwg_scoreboard_pkg.sv
// Sample predictor and scoreboard for the multi-waveform generator testbench.
`timescale 1ns / 1ps

package mwg_tb_pkg;
	import mwg_pkg::*;

	localparam logic [31:0] TICK_STEP_AT_RESET = 32'd429496730;
	localparam logic [31:0] NOISE_FALLBACK     = 32'd2463534242;

	// Angles in degrees with 32 fraction bits
	localparam longint unsigned UNIT         = 64'h0000_0001_0000_0000;
	localparam longint unsigned HALF_TURN    = 64'h0000_00B4_0000_0000;
	localparam longint unsigned QUARTER_TURN = 64'h0000_005A_0000_0000;

	localparam longint S32_MAX = 64'sd2147483647;
	localparam longint S32_MIN = -64'sd2147483648;

	// round(sin * 65536) at whole degrees, 0 to 90
	localparam int unsigned QUARTER_WAVE [91] = '{
		0, 1144, 2287, 3430, 4572, 5712, 6850, 7987, 9121, 10252,
		11380, 12505, 13626, 14742, 15855, 16962, 18064, 19161, 20252, 21336,
		22415, 23486, 24550, 25607, 26656, 27697, 28729, 29753, 30767, 31773,
		32768, 33754, 34729, 35693, 36647, 37590, 38521, 39441, 40348, 41243,
		42126, 42995, 43852, 44695, 45525, 46341, 47143, 47930, 48703, 49461,
		50203, 50931, 51643, 52339, 53020, 53684, 54332, 54963, 55578, 56175,
		56756, 57319, 57865, 58393, 58903, 59396, 59870, 60326, 60764, 61183,
		61584, 61966, 62328, 62672, 62997, 63303, 63589, 63856, 64104, 64332,
		64540, 64729, 64898, 65047, 65177, 65287, 65376, 65446, 65496, 65526,
		65536
	};

	class sample_scoreboard;
		logic [2:0]         wave_sel;
		logic [31:0]        bias;
		logic [31:0]        amp;
		logic [31:0]        tick_step;
		logic [31:0]        ms_step;
		logic [31:0]        phase;
		logic [31:0]        noise;
		logic signed [31:0] due_samples [$];
		int unsigned        mismatches;
		int unsigned        compared;
		int unsigned        kind_count [4];

		function new();
			wave_sel   = WAVE_SINE;
			bias       = '0;
			amp        = '0;
			tick_step  = TICK_STEP_AT_RESET;
			ms_step    = '0;
			phase      = '0;
			noise      = NOISE_FALLBACK;
			mismatches = 0;
			compared   = 0;
			foreach (kind_count[i])
				kind_count[i] = 0;
		endfunction

		// Register write as seen by the block
		function void load_register(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				REG_WAVE_TYPE: wave_sel = value[2:0];
				REG_BIAS:      bias = value;
				REG_AMP:       amp = value;
				REG_TICK_STEP: tick_step = value;
				REG_MS_STEP:   ms_step = value;
				REG_SEED:      noise = (value == 32'd0) ? NOISE_FALLBACK : value;
				default:       ;
			endcase
		endfunction

		function longint clamp32(longint v);
			if (v > S32_MAX)
				return S32_MAX;
			if (v < S32_MIN)
				return S32_MIN;
			return v;
		endfunction

		// Folded quarter-wave lookup with linear interpolation, rounding half up
		function longint sine_at(logic [31:0] ph);
			longint unsigned deg;
			longint unsigned frac;
			longint unsigned acc;
			int unsigned     idx;
			bit              neg;
			longint          v;
			deg = {32'b0, ph} * 64'd360;
			neg = 1'b0;
			if (deg > HALF_TURN) begin
				deg = deg - HALF_TURN;
				neg = 1'b1;
			end
			if (deg > QUARTER_TURN)
				deg = HALF_TURN - deg;
			idx = deg[63:32];
			if (idx >= 90) begin
				v = QUARTER_WAVE[90];
			end else begin
				frac = {32'b0, deg[31:0]};
				acc = QUARTER_WAVE[idx] * (UNIT - frac) + QUARTER_WAVE[idx + 1] * frac
					+ 64'h8000_0000;
				v = acc >> 32;
			end
			return neg ? -v : v;
		endfunction

		// xorshift32 step, then scale to [-1, 1] in Q16.16
		function longint next_noise();
			logic [31:0]     x;
			longint unsigned num;
			x = noise;
			x = x ^ (x << 13);
			x = x ^ (x >> 17);
			x = x ^ (x << 5);
			noise = x;
			num = {32'b0, x} * 64'd131072 + 64'd2147483647;
			return longint'(num / 64'hFFFF_FFFF) - 65536;
		endfunction

		// Waveform at the current phase, biased and clamped where it applies
		function longint waveform();
			longint b;
			longint q;
			b = $signed(bias);
			q = {46'b0, phase[31:14]};
			case (wave_sel)
				WAVE_SINE:   return clamp32(sine_at(phase) + b);
				WAVE_TRI: begin
					if (phase < 32'h4000_0000)
						return clamp32(q + b);
					if (phase < 32'hC000_0000)
						return clamp32(131072 - q + b);
					return clamp32(q - 262144 + b);
				end
				WAVE_SAW:    return {48'b0, phase[31:16]};
				WAVE_ISAW:   return -longint'({48'b0, phase[31:16]});
				WAVE_SQUARE: return clamp32((phase[31] ? -65536 : 65536) + b);
				WAVE_NOISE:  return clamp32(next_noise() + b);
				default:     return 0;
			endcase
		endfunction

		// Accepted input beat: work out its sample and advance the state
		function void predict_sample(kind_t k, logic [31:0] ems);
			longint          w;
			longint          s;
			longint unsigned mag;
			longint unsigned adv;
			kind_count[k]++;
			case (k)
				KIND_TICK: begin
					s = waveform();
					phase = phase + tick_step;
				end
				KIND_TIMED: begin
					w = waveform();
					mag = (w < 0) ? -w : w;
					mag = (mag * amp + 64'd32768) >> 16;
					if (mag > UNIT)
						mag = UNIT;
					s = clamp32((w < 0) ? -longint'(mag) : longint'(mag));
					adv = {32'b0, ems} * {32'b0, ms_step};
					phase = phase + adv[47:16];
				end
				KIND_CLEAR: begin
					phase = '0;
					s = 0;
				end
				default: s = 0;
			endcase
			due_samples.push_back(s[31:0]);
		endfunction

		// Output beat: compare with the oldest outstanding sample
		function void check_sample(logic signed [31:0] got);
			logic signed [31:0] want;
			if (due_samples.size() == 0) begin
				$error("sample: beat with nothing outstanding, actual %0d", got);
				mismatches++;
				return;
			end
			want = due_samples.pop_front();
			compared++;
			if (got !== want) begin
				$error("sample: expected %0d, actual %0d", want, got);
				mismatches++;
			end
		endfunction
	endclass

endpackage

### test/tb_top.sv
// Top-level testbench for the multi-waveform generator: stimulus, handshakes and result check.
`timescale 1ns / 1ps

module tb_top;
	import mwg_pkg::*;
	import mwg_tb_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 200000;

	logic                 clk        = 1'b0;
	logic                 arst_n     = 1'b0;
	logic                 in_valid   = 1'b0;
	logic [1:0]           kind       = '0;
	logic [31:0]          elapsed_ms = '0;
	logic                 out_stall  = 1'b0;
	logic                 cfg_valid  = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index  = '0;
	logic [31:0]          cfg_data   = '0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 cfg_ready;
	logic signed [31:0]   sample;

	bit               calm          = 1'b0;
	int unsigned      stall_left    = 0;
	int unsigned      cycle_count   = 0;
	int unsigned      setting_count = 0;
	sample_scoreboard sb            = new();

	multi_waveform_generator dut (
		.clk,
		.arst_n,
		.in_valid,
		.in_stall,
		.kind,
		.elapsed_ms,
		.out_valid,
		.out_stall,
		.sample,
		.cfg_valid,
		.cfg_ready,
		.cfg_index,
		.cfg_data
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Result side: check each accepted beat, then pick the stall for the next cycle
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			sb.check_sample(sample);
		if (stall_left != 0) begin
			out_stall <= 1'b1;
			stall_left = stall_left - 1;
		end else if (!calm && $urandom_range(0, 99) < 2) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 5);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles, %0d samples outstanding",
				cycle_count, sb.due_samples.size());
			$display("Verification failed");
			$finish;
		end
	end

	// One input beat, with an occasional gap before it
	task automatic send_item(input kind_t k, input logic [31:0] ems);
		int unsigned gap;
		gap = (!calm && $urandom_range(0, 99) < 2) ? $urandom_range(1, 6) : 0;
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid   <= 1'b1;
		kind       <= k;
		elapsed_ms <= ems;
		do @(posedge clk); while (in_stall);
		sb.predict_sample(k, ems);
	endtask

	// Hold off input until every outstanding sample is back
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.due_samples.size() != 0)
			@(posedge clk);
	endtask

	// Register write; valid stays up for a following write
	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		sb.load_register(idx, value);
	endtask

	// New register setting, applied with the block idle
	task automatic apply_setting(input logic [31:0] wave_word, input logic [31:0] bias_word,
			input logic [31:0] amp_word, input logic [31:0] tick_word,
			input logic [31:0] ms_word, input bit load_seed, input logic [31:0] seed_word);
		drain();
		write_register(REG_WAVE_TYPE, wave_word);
		write_register(REG_BIAS, bias_word);
		write_register(REG_AMP, amp_word);
		write_register(REG_TICK_STEP, tick_word);
		write_register(REG_MS_STEP, ms_word);
		if (load_seed)
			write_register(REG_SEED, seed_word);
		cfg_valid <= 1'b0;
		setting_count++;
	endtask

	// A typical value, an extreme or a full random word, each about a third of the time
	function automatic logic [31:0] pick_word(input logic [31:0] typical);
		case ($urandom_range(0, 5))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			2, 3:    return $urandom;
			default: return typical;
		endcase
	endfunction

	initial begin
		int unsigned n;
		int unsigned r;
		kind_t       k;
		logic [31:0] ems;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: sine at a tenth of a period per tick, wraps on the tenth
		repeat (11) send_item(KIND_TICK, 32'd0);
		send_item(KIND_TIMED, 32'hFFFF_FFFF);
		send_item(KIND_NOP, 32'hFFFF_FFFF);

		// Sine at the quarter points, including the top of the table
		apply_setting(WAVE_SINE, 32'd0, 32'h0001_0000, 32'h4000_0000, 32'd0, 1'b0, 32'd0);
		send_item(KIND_CLEAR, 32'h0);
		repeat (4) send_item(KIND_TICK, 32'h0);

		// Square with largest bias, gain and timed step: positive saturation
		apply_setting(WAVE_SQUARE, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF,
			1'b0, 32'd0);
		send_item(KIND_TIMED, 32'hFFFF_FFFF);
		send_item(KIND_TIMED, 32'h0000_0000);

		// Noise from the fallback seed with most negative bias: negative saturation
		apply_setting(WAVE_NOISE, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0,
			1'b1, 32'd0);
		send_item(KIND_TIMED, $urandom);
		send_item(KIND_TICK, 32'h0);

		// Random settings, each wave type in turn; one phase runs without idling
		for (int p = 0; p < 10; p++) begin
			calm = (p == 4);
			apply_setting(($urandom & 32'hFFFF_FFF8) | ((p < 8) ? p : $urandom_range(0, 7)),
				pick_word($urandom_range(0, 32'h0004_0000) - 32'h0002_0000),
				pick_word($urandom_range(0, 32'h0003_0000)),
				pick_word($urandom_range(1, 32'h1000_0000)),
				pick_word($urandom_range(0, 32'h0100_0000)),
				$urandom_range(0, 1), pick_word($urandom));
			n = $urandom_range(60, 80);
			repeat (n) begin
				r = $urandom_range(0, 99);
				if (r < 58)
					k = KIND_TICK;
				else if (r < 88)
					k = KIND_TIMED;
				else if (r < 95)
					k = KIND_CLEAR;
				else
					k = KIND_NOP;
				ems = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h0004_0000);
				send_item(k, ems);
			end
		end
		calm = 1'b0;

		drain();
		repeat (20) @(posedge clk);
		if (sb.due_samples.size() != 0)
			$error("sample: %0d expected beats never arrived", sb.due_samples.size());

		$display("Covered %0d ticks, %0d timed steps, %0d clears and %0d unused kinds",
			sb.kind_count[KIND_TICK], sb.kind_count[KIND_TIMED], sb.kind_count[KIND_CLEAR],
			sb.kind_count[KIND_NOP]);
		$display("over %0d register settings; %0d samples compared, %0d mismatches",
			setting_count, sb.compared, sb.mismatches);
		if (sb.mismatches == 0 && sb.due_samples.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
